// ===== hdl/abld_pkg.sv =====
package abld_pkg;

    localparam int unsigned SampleWidth = 12;
    localparam int unsigned CountWidth  = 8;
    localparam int unsigned MaskWidth   = 4;
    localparam int unsigned CfgIdxWidth = 3;
    localparam int unsigned CfgWidth    = 12;

    typedef logic [SampleWidth-1:0] t_sample;
    typedef logic [CountWidth-1:0]  t_count;
    typedef logic [MaskWidth-1:0]   t_mask;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_LEVEL_ENTER     = 3'd0,
        REG_LEVEL_ESC       = 3'd1,
        REG_LEVEL_RIGHT     = 3'd2,
        REG_LEVEL_LEFT      = 3'd3,
        REG_LEVEL_CEILING   = 3'd4,
        REG_SHUTDOWN_LEVEL  = 3'd5,
        REG_DEBOUNCE_COUNT  = 3'd6,
        REG_WATCHED_BUTTONS = 3'd7
    } t_cfg_idx;

    localparam t_sample RST_LEVEL_ENTER    = 12'd2053;
    localparam t_sample RST_LEVEL_ESC      = 12'd1017;
    localparam t_sample RST_LEVEL_RIGHT    = 12'd403;
    localparam t_sample RST_LEVEL_LEFT     = 12'd125;
    localparam t_sample RST_LEVEL_CEILING  = 12'd4000;
    localparam t_sample RST_SHUTDOWN_LEVEL = 12'd3070;
    localparam t_count  RST_DEBOUNCE_COUNT = 8'd3;
    localparam t_mask   RST_WATCHED        = 4'd0;
    localparam t_count  RST_COUNTDOWN      = 8'd3;

    localparam t_sample ENTER_OFFSET = 12'h7ff;
    localparam logic [SampleWidth:0] NEAR_BAND = 13'd8;

    localparam t_mask MASK_ENTER = 4'b0001;
    localparam t_mask MASK_ESC   = 4'b0010;
    localparam t_mask MASK_LEFT  = 4'b0100;
    localparam t_mask MASK_RIGHT = 4'b1000;

endpackage

// ===== hdl/analog_button_ladder_debounce_unit.sv =====
// Channel  Handshake                  Payload
// in       i_in_valid / o_in_ready    i_sample
// out      o_out_valid / i_out_ready  o_held_value, o_button_mask, o_pressed,
//                                     o_match, o_shutdown
// cfg      i_cfg_we (no handshake)    i_cfg_idx, i_cfg_data
//
// One sample per cycle. The state update and decode for a sample happen in the
// cycle it is accepted; its result appears in the output register on the next
// cycle. Input is taken whenever the output register is empty or being drained
// in the same cycle, so a stall on the out side backs up after one result.
// Synchronous active-low reset restores register defaults and clears state.
module analog_button_ladder_debounce_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [abld_pkg::CfgIdxWidth-1:0] i_cfg_idx,
    input  logic [abld_pkg::CfgWidth-1:0]  i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  abld_pkg::t_sample              i_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output abld_pkg::t_sample              o_held_value,
    output abld_pkg::t_mask                o_button_mask,
    output logic                           o_pressed,
    output logic                           o_match,
    output logic                           o_shutdown
);

    // configuration
    abld_pkg::t_sample r_level_enter, r_level_esc, r_level_right, r_level_left;
    abld_pkg::t_sample r_level_ceiling, r_shutdown_level;
    abld_pkg::t_count  r_debounce_count;
    abld_pkg::t_mask   r_watched;

    // debounce state
    abld_pkg::t_sample r_held, r_previous;
    logic              r_debouncing;
    abld_pkg::t_count  r_countdown;

    abld_pkg::t_sample n_held, n_previous;
    logic              n_debouncing;
    abld_pkg::t_count  n_countdown;

    // result register
    logic              r_out_valid;
    abld_pkg::t_sample r_res_held;
    abld_pkg::t_mask   r_res_mask;
    logic              r_res_pressed, r_res_match, r_res_shutdown;

    logic              in_fire;
    logic              deb_now;
    abld_pkg::t_sample half_left, thr_enter, thr_esc, thr_right;
    abld_pkg::t_sample dec_v;
    abld_pkg::t_mask   dec_mask;
    logic              dec_pressed, dec_match, dec_shutdown;
    logic [abld_pkg::SampleWidth:0] prev_ext, sd_ext;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_enter    <= abld_pkg::RST_LEVEL_ENTER;
            r_level_esc      <= abld_pkg::RST_LEVEL_ESC;
            r_level_right    <= abld_pkg::RST_LEVEL_RIGHT;
            r_level_left     <= abld_pkg::RST_LEVEL_LEFT;
            r_level_ceiling  <= abld_pkg::RST_LEVEL_CEILING;
            r_shutdown_level <= abld_pkg::RST_SHUTDOWN_LEVEL;
            r_debounce_count <= abld_pkg::RST_DEBOUNCE_COUNT;
            r_watched        <= abld_pkg::RST_WATCHED;
        end else if (i_cfg_we) begin
            case (abld_pkg::t_cfg_idx'(i_cfg_idx))
                abld_pkg::REG_LEVEL_ENTER:     r_level_enter    <= i_cfg_data;
                abld_pkg::REG_LEVEL_ESC:       r_level_esc      <= i_cfg_data;
                abld_pkg::REG_LEVEL_RIGHT:     r_level_right    <= i_cfg_data;
                abld_pkg::REG_LEVEL_LEFT:      r_level_left     <= i_cfg_data;
                abld_pkg::REG_LEVEL_CEILING:   r_level_ceiling  <= i_cfg_data;
                abld_pkg::REG_SHUTDOWN_LEVEL:  r_shutdown_level <= i_cfg_data;
                abld_pkg::REG_DEBOUNCE_COUNT:
                    r_debounce_count <= i_cfg_data[abld_pkg::CountWidth-1:0];
                abld_pkg::REG_WATCHED_BUTTONS:
                    r_watched <= i_cfg_data[abld_pkg::MaskWidth-1:0];
                default: ;
            endcase
        end
    end

    assign half_left = r_level_left >> 1;
    assign thr_enter = abld_pkg::t_sample'(({1'b0, r_level_enter} + {1'b0, r_level_esc}) >> 1);
    assign thr_esc   = abld_pkg::t_sample'(({1'b0, r_level_esc} + {1'b0, r_level_right}) >> 1);
    assign thr_right = abld_pkg::t_sample'(({1'b0, r_level_right} + {1'b0, r_level_left}) >> 1);

    // next debounce state for the incoming sample
    always_comb begin
        n_held       = r_held;
        n_previous   = r_previous;
        n_debouncing = r_debouncing;
        n_countdown  = r_countdown;
        // a drop to zero while something is held re-enters debounce
        deb_now      = r_debouncing || (i_sample == '0 && r_held != '0);
        if (i_sample < r_level_ceiling) begin
            n_debouncing = deb_now;
            n_previous   = i_sample;
            if ((i_sample > half_left || deb_now) && r_previous == i_sample) begin
                if (deb_now) begin
                    if (r_countdown != '0) begin
                        n_countdown = r_countdown - abld_pkg::t_count'(1);
                    end else begin
                        n_debouncing = 1'b0;
                        n_held       = i_sample;
                    end
                end else begin
                    n_debouncing = 1'b1;
                    n_countdown  = r_debounce_count;
                end
            end
        end
    end

    // decode of the updated held value
    always_comb begin
        dec_mask = '0;
        dec_v    = n_held;
        if (n_held > thr_enter) begin
            dec_mask = dec_mask | abld_pkg::MASK_ENTER;
            dec_v    = (n_held >= abld_pkg::ENTER_OFFSET) ?
                       n_held - abld_pkg::ENTER_OFFSET : '0;
        end
        if (dec_v > thr_esc) begin
            dec_mask = dec_mask | abld_pkg::MASK_ESC;
        end else if (dec_v > thr_right) begin
            dec_mask = dec_mask | abld_pkg::MASK_LEFT;
        end else if (dec_v > half_left) begin
            dec_mask = dec_mask | abld_pkg::MASK_RIGHT;
        end
    end

    assign dec_pressed = (n_held > half_left) || (dec_mask != '0);
    assign dec_match   = dec_pressed && (dec_mask == r_watched);

    // band check without wrap: level-8 <= prev <= level+8
    assign prev_ext     = {1'b0, n_previous};
    assign sd_ext       = {1'b0, r_shutdown_level};
    assign dec_shutdown = !n_debouncing && (sd_ext <= prev_ext + abld_pkg::NEAR_BAND)
                          && (prev_ext <= sd_ext + abld_pkg::NEAR_BAND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= '0;
            r_previous   <= '0;
            r_debouncing <= 1'b0;
            r_countdown  <= abld_pkg::RST_COUNTDOWN;
        end else if (in_fire) begin
            r_held       <= n_held;
            r_previous   <= n_previous;
            r_debouncing <= n_debouncing;
            r_countdown  <= n_countdown;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_res_held     <= n_held;
            r_res_mask     <= dec_mask;
            r_res_pressed  <= dec_pressed;
            r_res_match    <= dec_match;
            r_res_shutdown <= dec_shutdown;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_held_value  = r_res_held;
    assign o_button_mask = r_res_mask;
    assign o_pressed     = r_res_pressed;
    assign o_match       = r_res_match;
    assign o_shutdown    = r_res_shutdown;

endmodule

// ===== bench/analog_button_ladder_debounce_unit_test.sv =====
module analog_button_ladder_debounce_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 250000;
    localparam int RANDOM_PER_PHASE = 60;

    typedef struct packed {
        abld_pkg::t_sample held_value;
        abld_pkg::t_mask   button_mask;
        logic              pressed;
        logic              match;
        logic              shutdown;
    } t_ladder_report;

    class ladder_scoreboard;
        abld_pkg::t_sample lvl_enter, lvl_esc, lvl_right, lvl_left;
        abld_pkg::t_sample lvl_ceiling, lvl_shutdown;
        abld_pkg::t_count  settle_count;
        abld_pkg::t_mask   watched;

        abld_pkg::t_sample held;
        abld_pkg::t_sample prev_sample;
        bit                settling;
        abld_pkg::t_count  countdown;

        t_ladder_report expected_reports[$];
        int errors;
        int checked;
        int latches;
        int shutdowns;
        int match_count;

        function new();
            lvl_enter    = abld_pkg::RST_LEVEL_ENTER;
            lvl_esc      = abld_pkg::RST_LEVEL_ESC;
            lvl_right    = abld_pkg::RST_LEVEL_RIGHT;
            lvl_left     = abld_pkg::RST_LEVEL_LEFT;
            lvl_ceiling  = abld_pkg::RST_LEVEL_CEILING;
            lvl_shutdown = abld_pkg::RST_SHUTDOWN_LEVEL;
            settle_count = abld_pkg::RST_DEBOUNCE_COUNT;
            watched      = abld_pkg::RST_WATCHED;
            held         = '0;
            prev_sample  = '0;
            settling     = 1'b0;
            countdown    = abld_pkg::RST_COUNTDOWN;
        endfunction

        function void set_reg(abld_pkg::t_cfg_idx idx, int unsigned value);
            case (idx)
                abld_pkg::REG_LEVEL_ENTER:     lvl_enter    = value[11:0];
                abld_pkg::REG_LEVEL_ESC:       lvl_esc      = value[11:0];
                abld_pkg::REG_LEVEL_RIGHT:     lvl_right    = value[11:0];
                abld_pkg::REG_LEVEL_LEFT:      lvl_left     = value[11:0];
                abld_pkg::REG_LEVEL_CEILING:   lvl_ceiling  = value[11:0];
                abld_pkg::REG_SHUTDOWN_LEVEL:  lvl_shutdown = value[11:0];
                abld_pkg::REG_DEBOUNCE_COUNT:  settle_count = value[7:0];
                abld_pkg::REG_WATCHED_BUTTONS: watched      = value[3:0];
                default: ;
            endcase
        endfunction

        function abld_pkg::t_mask decode_buttons(abld_pkg::t_sample reading);
            int              v;
            abld_pkg::t_mask m;
            v = int'(reading);
            m = '0;
            if (v > (int'(lvl_enter) + int'(lvl_esc)) / 2) begin
                m |= abld_pkg::MASK_ENTER;
                // clamps at zero instead of wrapping
                v = (v >= int'(abld_pkg::ENTER_OFFSET)) ?
                    v - int'(abld_pkg::ENTER_OFFSET) : 0;
            end
            if (v > (int'(lvl_esc) + int'(lvl_right)) / 2)
                m |= abld_pkg::MASK_ESC;
            else if (v > (int'(lvl_right) + int'(lvl_left)) / 2)
                m |= abld_pkg::MASK_LEFT;
            else if (v > int'(lvl_left) / 2)
                m |= abld_pkg::MASK_RIGHT;
            return m;
        endfunction

        function void note_sample(abld_pkg::t_sample s);
            t_ladder_report r;
            int lo, hi;
            // readings at or above the ceiling leave the state alone
            if (s < lvl_ceiling) begin
                if (s == '0 && held != '0)
                    settling = 1'b1;
                if (s > lvl_left / 2 || settling) begin
                    if (prev_sample == s) begin
                        if (settling) begin
                            if (countdown > 0) begin
                                countdown--;
                            end else begin
                                settling = 1'b0;
                                held     = s;
                                latches++;
                            end
                        end else begin
                            settling  = 1'b1;
                            countdown = settle_count;
                        end
                    end
                end
                prev_sample = s;
            end
            lo = int'(lvl_shutdown) - int'(abld_pkg::NEAR_BAND);
            hi = int'(lvl_shutdown) + int'(abld_pkg::NEAR_BAND);
            r.held_value  = held;
            r.button_mask = decode_buttons(held);
            r.pressed     = (held > lvl_left / 2) || (r.button_mask != '0);
            r.match       = r.pressed && (r.button_mask == watched);
            r.shutdown    = !settling && lo <= int'(prev_sample) && int'(prev_sample) <= hi;
            shutdowns   += r.shutdown;
            match_count += r.match;
            expected_reports.push_back(r);
        endfunction

        function void field_check(string name, logic [11:0] want, logic [11:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_report(t_ladder_report got);
            t_ladder_report want;
            if (expected_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, expected none, actual held=%0d mask=%b",
                         $time, got.held_value, got.button_mask);
                return;
            end
            want = expected_reports.pop_front();
            checked++;
            field_check("held_value", want.held_value, got.held_value);
            field_check("button_mask", want.button_mask, got.button_mask);
            field_check("pressed", want.pressed, got.pressed);
            field_check("match", want.match, got.match);
            field_check("shutdown", want.shutdown, got.shutdown);
        endfunction
    endclass

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_cfg_we = 1'b0;
    logic [abld_pkg::CfgIdxWidth-1:0] i_cfg_idx = '0;
    logic [abld_pkg::CfgWidth-1:0]    i_cfg_data = '0;
    logic    i_in_valid = 1'b0;
    abld_pkg::t_sample i_sample = '0;
    logic    i_out_ready = 1'b0;
    logic    o_in_ready;
    logic    o_out_valid;
    abld_pkg::t_sample o_held_value;
    abld_pkg::t_mask   o_button_mask;
    logic    o_pressed;
    logic    o_match;
    logic    o_shutdown;

    ladder_scoreboard sb;
    t_ladder_report   seen_report;
    int  cycle_count = 0;
    int  samples_sent = 0;
    int  settings_applied = 0;
    bit  send_quiet = 1'b0;
    bit  sink_quiet = 1'b0;

    analog_button_ladder_debounce_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_sample      (i_sample),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_held_value  (o_held_value),
        .o_button_mask (o_button_mask),
        .o_pressed     (o_pressed),
        .o_match       (o_match),
        .o_shutdown    (o_shutdown)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen_report.held_value  = o_held_value;
            seen_report.button_mask = o_button_mask;
            seen_report.pressed     = o_pressed;
            seen_report.match       = o_match;
            seen_report.shutdown    = o_shutdown;
            sb.check_report(seen_report);
        end
    end

    // result side: random stalls, with quiet stretches
    initial begin : out_side
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                sink_quiet = !sink_quiet;
            stall = sink_quiet ? 0 : $urandom_range(0, 13);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic cfg_write(input abld_pkg::t_cfg_idx idx, input int unsigned value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[abld_pkg::CfgWidth-1:0];
        sb.set_reg(idx, value);
    endtask

    task automatic apply_settings(input int enter, input int esc, input int right,
                                  input int left, input int ceiling, input int shut,
                                  input int count, input int watch);
        cfg_write(abld_pkg::REG_LEVEL_ENTER, enter);
        cfg_write(abld_pkg::REG_LEVEL_ESC, esc);
        cfg_write(abld_pkg::REG_LEVEL_RIGHT, right);
        cfg_write(abld_pkg::REG_LEVEL_LEFT, left);
        cfg_write(abld_pkg::REG_LEVEL_CEILING, ceiling);
        cfg_write(abld_pkg::REG_SHUTDOWN_LEVEL, shut);
        cfg_write(abld_pkg::REG_DEBOUNCE_COUNT, count);
        cfg_write(abld_pkg::REG_WATCHED_BUTTONS, watch);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    task automatic send_sample(input abld_pkg::t_sample s);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_quiet = !send_quiet;
        gap = send_quiet ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_sample(s);
        samples_sent++;
    endtask

    task automatic send_run(input abld_pkg::t_sample s, input int n);
        repeat (n) send_sample(s);
    endtask

    // waits until every report is back so the registers can change
    task automatic drain();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (sb.expected_reports.size() != 0 && waited < 400) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (3) @(posedge i_clk);
    endtask

    function automatic abld_pkg::t_sample pick_reading();
        int v;
        case ($urandom_range(0, 9))
            0: v = sb.lvl_enter;
            1: v = sb.lvl_esc;
            2: v = sb.lvl_right;
            3: v = sb.lvl_left;
            4: v = sb.lvl_shutdown;
            5: v = 0;
            6: v = int'(sb.lvl_enter) + int'(sb.lvl_esc);
            7: v = sb.lvl_ceiling;
            default: v = $urandom_range(0, 4095);
        endcase
        if ($urandom_range(0, 1) == 1)
            v = v + $urandom_range(0, 20) - 10;
        if (v < 0)
            v = 0;
        else if (v > 4095)
            v = 4095;
        return abld_pkg::t_sample'(v);
    endfunction

    // mostly runs long enough to latch, some cut short, some lone noise
    task automatic random_runs(input int n);
        int                sent;
        int                kind;
        int                len;
        abld_pkg::t_sample v;
        sent = 0;
        while (sent < n) begin
            kind = $urandom_range(0, 9);
            v    = pick_reading();
            if (kind < 7)
                len = int'(sb.settle_count) + 3 + $urandom_range(0, 2);
            else if (kind < 9)
                len = $urandom_range(1, int'(sb.settle_count) + 2);
            else begin
                len = 1;
                v   = abld_pkg::t_sample'($urandom_range(0, 4095));
            end
            send_run(v, len);
            sent += len;
        end
    endtask

    task automatic random_settings();
        int left, right, esc, enter;
        left  = $urandom_range(20, 400);
        right = left + $urandom_range(40, 600);
        esc   = right + $urandom_range(40, 800);
        enter = esc + $urandom_range(40, 1800);
        apply_settings(enter, esc, right, left, $urandom_range(3000, 4095),
                       $urandom_range(0, 4095), $urandom_range(0, 6), $urandom_range(0, 15));
    endtask

    initial begin : main
        int p;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero count so a run of three latches
        apply_settings(abld_pkg::RST_LEVEL_ENTER, abld_pkg::RST_LEVEL_ESC,
                       abld_pkg::RST_LEVEL_RIGHT, abld_pkg::RST_LEVEL_LEFT,
                       abld_pkg::RST_LEVEL_CEILING, abld_pkg::RST_SHUTDOWN_LEVEL, 0,
                       abld_pkg::MASK_ENTER);
        send_sample(12'd4095);
        send_sample(12'd4000);
        send_sample(12'd3999);
        send_run(12'd2053, 3);
        send_run(12'd1600, 3);          // enter decoded, remainder clamps to zero
        send_run(12'd0, 2);             // fall to zero re-enters debounce
        send_run(12'd3070, 3);
        send_sample(12'd3062);          // shutdown band edges
        send_sample(12'd3078);
        send_sample(12'd3079);
        send_sample(12'd3061);
        send_run(12'd1017, 3);
        send_run(12'd62, 2);            // at half the left level: not tracked
        send_sample(12'd63);
        drain();

        for (p = 1; p <= 8; p++) begin
            case (p)
                1: apply_settings(abld_pkg::RST_LEVEL_ENTER, abld_pkg::RST_LEVEL_ESC,
                                  abld_pkg::RST_LEVEL_RIGHT, abld_pkg::RST_LEVEL_LEFT,
                                  abld_pkg::RST_LEVEL_CEILING, abld_pkg::RST_SHUTDOWN_LEVEL,
                                  abld_pkg::RST_DEBOUNCE_COUNT, abld_pkg::MASK_ESC);
                2: apply_settings(3300, 1900, 900, 300, 4095, 0, 0, abld_pkg::MASK_LEFT);
                3: apply_settings(4095, 4095, 4095, 4095, 4095, 4095, 255, 0);
                4: apply_settings(0, 0, 0, 0, 4095, 0, 0, 15);
                5: apply_settings(0, 0, 0, 0, 0, 0, 0, 0);
                default: random_settings();
            endcase
            case (p)
                3: begin
                    // longest debounce: one full run, then ignored and zero readings
                    send_run(12'd4094, 260);
                    send_run(12'd4095, 3);
                    send_run(12'd0, 3);
                end
                4: random_runs(60);
                5: random_runs(12);     // ceiling at zero: everything ignored
                default: random_runs(RANDOM_PER_PHASE);
            endcase
            drain();
        end

        repeat (5) @(posedge i_clk);
        if (sb.expected_reports.size() != 0) begin
            sb.errors++;
            $display("%0t: %0d expected transactions never arrived", $time,
                     sb.expected_reports.size());
        end
        $display("Sent %0d ladder readings under %0d register settings, %0d reports checked.",
                 samples_sent, settings_applied, sb.checked);
        $display("Predicted %0d latches, %0d shutdown flags, %0d watched-mask hits.",
                 sb.latches, sb.shutdowns, sb.match_count);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
